[src/h264d_pkg.sv]
package h264d_pkg;

  localparam int DEFAULT_FRAME_COUNT_BITS = 24;
  localparam int JOB_DEPTH = 4;

  localparam logic [15:0] HEADER_BYTES    = 16'd12;
  localparam logic [15:0] IDX_MARKER      = 16'd1;
  localparam logic [15:0] IDX_STAMP_FIRST = 16'd4;
  localparam logic [15:0] IDX_STAMP_LAST  = 16'd7;
  localparam logic [15:0] IDX_HEADER_LAST = 16'd11;

  localparam logic [4:0] NAL_IDR        = 5'd5;
  localparam logic [4:0] NAL_SINGLE_MIN = 5'd1;
  localparam logic [4:0] NAL_SINGLE_MAX = 5'd23;
  localparam logic [4:0] NAL_STAP_A     = 5'd24;
  localparam logic [4:0] NAL_FU_A       = 5'd28;
  localparam logic [7:0] NRI_MASK       = 8'he0;

  // Aggregate phase codes
  localparam logic [1:0] AGG_SIZE_HI   = 2'd0;
  localparam logic [1:0] AGG_SIZE_LO   = 2'd1;
  localparam logic [1:0] AGG_UNIT      = 2'd2;
  localparam logic [1:0] AGG_FIRST_HI  = 2'd3;
  localparam logic [1:0] FU_HDR        = 2'd0;
  localparam logic [1:0] FU_BODY       = 2'd1;

  // Result slots of one job
  localparam logic [2:0] PH_SC0  = 3'd0;
  localparam logic [2:0] PH_SC3  = 3'd3;
  localparam logic [2:0] PH_BYTE = 3'd4;
  localparam logic [2:0] PH_END  = 3'd5;

  localparam logic KIND_BYTE      = 1'b0;
  localparam logic KIND_FRAME_END = 1'b1;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_HEADER,
    MODE_SELECT,
    MODE_SINGLE,
    MODE_STAP,
    MODE_FU,
    MODE_DROP
  } mode_t;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic        packet_start;
    logic [15:0] packet_length;
  } in_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  stream_byte;
    logic        key_frame;
    logic [23:0] frame_length;
    logic        last_of_run;
  } result_t;

  // Everything one input beat produces
  typedef struct packed {
    logic        start_code;
    logic        has_byte;
    logic [7:0]  data;
    logic        frame_end;
    logic        key;
    logic [23:0] length;
  } job_t;

endpackage

[src/h264d_front.sv]
module h264d_front import h264d_pkg::*; #(
  parameter int FRAME_COUNT_BITS = DEFAULT_FRAME_COUNT_BITS
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  in_t     in_item,
  input  logic    q_full,
  output logic    q_push,
  output job_t    q_job
);

  logic [15:0] byte_index, byte_index_next;
  logic [15:0] packet_total, packet_total_next;
  logic [23:0] stamp_partial, stamp_partial_next;
  logic [31:0] last_stamp, last_stamp_next;
  logic        frame_open, frame_open_next;
  logic        marker_flag, marker_flag_next;
  mode_t       mode, mode_next;
  logic [7:0]  indicator_byte, indicator_byte_next;
  logic [1:0]  aggregate_phase, aggregate_phase_next;
  logic [15:0] unit_remaining, unit_remaining_next;
  logic        key_seen, key_seen_next;
  logic [FRAME_COUNT_BITS-1:0] frame_bytes, frame_bytes_next;

  logic                      accept;
  mode_t                     mode_w;
  logic [15:0]               total_w;
  logic [15:0]               idx;
  logic [16:0]               idx_inc;
  logic [15:0]               here;
  logic [15:0]               size;
  logic [15:0]               remain_dec;
  logic [31:0]               stamp;
  logic [4:0]                unit_type;
  logic                      sc, hb, fe;
  logic [7:0]                dat;
  logic [2:0]                nbytes;
  logic [FRAME_COUNT_BITS:0] sum;
  logic [FRAME_COUNT_BITS-1:0] count_after;

  assign accept    = in_valid && !q_full;
  assign in_stall  = q_full;
  assign unit_type = in_item.rx_byte[4:0];

  always_comb begin
    byte_index_next      = byte_index;
    packet_total_next    = packet_total;
    stamp_partial_next   = stamp_partial;
    last_stamp_next      = last_stamp;
    frame_open_next      = frame_open;
    marker_flag_next     = marker_flag;
    mode_next            = mode;
    indicator_byte_next  = indicator_byte;
    aggregate_phase_next = aggregate_phase;
    unit_remaining_next  = unit_remaining;
    key_seen_next        = key_seen;
    sc    = 1'b0;
    hb    = 1'b0;
    fe    = 1'b0;
    dat   = in_item.rx_byte;
    stamp = {stamp_partial, in_item.rx_byte};
    size  = {unit_remaining[15:8], in_item.rx_byte};
    remain_dec = unit_remaining - 16'd1;

    if (in_item.packet_start) begin
      packet_total_next    = in_item.packet_length;
      byte_index_next      = '0;
      aggregate_phase_next = AGG_SIZE_HI;
      mode_next = (in_item.packet_length >= HEADER_BYTES) ? MODE_HEADER : MODE_IDLE;
    end
    mode_w  = mode_next;
    total_w = packet_total_next;
    idx     = byte_index_next;
    idx_inc = {1'b0, idx} + 17'd1;
    here    = total_w - idx;

    if (mode_w != MODE_IDLE) begin
      byte_index_next = idx_inc[15:0];
      case (mode_w)
        MODE_HEADER: begin
          if (idx == IDX_MARKER) begin
            marker_flag_next = in_item.rx_byte[7];
          end else if (idx >= IDX_STAMP_FIRST && idx < IDX_STAMP_LAST) begin
            stamp_partial_next = {stamp_partial[15:0], in_item.rx_byte};
          end else if (idx == IDX_STAMP_LAST) begin
            // close the open frame when the timestamp moves
            if (frame_open && stamp != last_stamp) fe = 1'b1;
            frame_open_next = 1'b1;
            last_stamp_next = stamp;
          end else if (idx == IDX_HEADER_LAST) begin
            mode_next = MODE_SELECT;
          end
        end
        MODE_SELECT: begin
          if (unit_type == NAL_IDR) key_seen_next = 1'b1;
          if (unit_type >= NAL_SINGLE_MIN && unit_type <= NAL_SINGLE_MAX) begin
            sc = 1'b1;
            hb = 1'b1;
            mode_next = MODE_SINGLE;
          end else if (unit_type == NAL_STAP_A) begin
            aggregate_phase_next = AGG_FIRST_HI;
            mode_next = MODE_STAP;
          end else if (unit_type == NAL_FU_A) begin
            indicator_byte_next  = in_item.rx_byte;
            aggregate_phase_next = FU_HDR;
            mode_next = MODE_FU;
          end else begin
            mode_next = MODE_DROP;
          end
        end
        MODE_SINGLE: begin
          hb = 1'b1;
        end
        MODE_STAP: begin
          if (aggregate_phase == AGG_SIZE_HI || aggregate_phase == AGG_FIRST_HI) begin
            if ((aggregate_phase == AGG_FIRST_HI && here < 16'd2) ||
                (aggregate_phase == AGG_SIZE_HI && here < 16'd3)) begin
              mode_next = MODE_DROP;
            end else begin
              unit_remaining_next  = {in_item.rx_byte, 8'h00};
              aggregate_phase_next = AGG_SIZE_LO;
            end
          end else if (aggregate_phase == AGG_SIZE_LO) begin
            // drop the rest when the unit overruns the packet
            if (size > here - 16'd1) begin
              mode_next = MODE_DROP;
            end else begin
              sc = 1'b1;
              if (size == '0) begin
                aggregate_phase_next = AGG_SIZE_HI;
              end else begin
                unit_remaining_next  = size;
                indicator_byte_next  = 8'd1;
                aggregate_phase_next = AGG_UNIT;
              end
            end
          end else begin
            if (indicator_byte != '0 && unit_type == NAL_IDR) key_seen_next = 1'b1;
            indicator_byte_next = '0;
            hb = 1'b1;
            unit_remaining_next = remain_dec;
            if (remain_dec == '0) aggregate_phase_next = AGG_SIZE_HI;
          end
        end
        MODE_FU: begin
          if (aggregate_phase == FU_HDR) begin
            if (unit_type == NAL_IDR) key_seen_next = 1'b1;
            if (in_item.rx_byte[7]) begin
              // rebuild the NAL header on the start fragment
              sc  = 1'b1;
              hb  = 1'b1;
              dat = (indicator_byte & NRI_MASK) | {3'b000, unit_type};
            end
            aggregate_phase_next = FU_BODY;
          end else begin
            hb = 1'b1;
          end
        end
        default: begin
        end
      endcase

      if (idx_inc >= {1'b0, total_w}) begin
        if (marker_flag_next) begin
          fe = 1'b1;
          frame_open_next = 1'b0;
        end
        mode_next = MODE_IDLE;
      end
    end

    nbytes = (sc ? 3'd4 : 3'd0) + (hb ? 3'd1 : 3'd0);
    sum = {1'b0, frame_bytes} + (FRAME_COUNT_BITS+1)'(nbytes);
    count_after = sum[FRAME_COUNT_BITS] ? '1 : sum[FRAME_COUNT_BITS-1:0];

    q_job.start_code = sc;
    q_job.has_byte   = hb;
    q_job.data       = dat;
    q_job.frame_end  = fe;
    q_job.key        = key_seen_next;
    q_job.length     = 24'(count_after);

    frame_bytes_next = fe ? '0 : count_after;
    if (fe) key_seen_next = 1'b0;

    q_push = accept && (sc || hb || fe);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index      <= '0;
      packet_total    <= '0;
      stamp_partial   <= '0;
      last_stamp      <= '0;
      frame_open      <= 1'b0;
      marker_flag     <= 1'b0;
      mode            <= MODE_IDLE;
      indicator_byte  <= '0;
      aggregate_phase <= '0;
      unit_remaining  <= '0;
      key_seen        <= 1'b0;
      frame_bytes     <= '0;
    end else if (accept) begin
      byte_index      <= byte_index_next;
      packet_total    <= packet_total_next;
      stamp_partial   <= stamp_partial_next;
      last_stamp      <= last_stamp_next;
      frame_open      <= frame_open_next;
      marker_flag     <= marker_flag_next;
      mode            <= mode_next;
      indicator_byte  <= indicator_byte_next;
      aggregate_phase <= aggregate_phase_next;
      unit_remaining  <= unit_remaining_next;
      key_seen        <= key_seen_next;
      frame_bytes     <= frame_bytes_next;
    end
  end

endmodule

[src/h264d_fifo.sv]
module h264d_fifo import h264d_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t head,
  output logic empty
);

  localparam int PTR_BITS = $clog2(JOB_DEPTH);

  job_t                mem [JOB_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [PTR_BITS:0]   count;

  assign full  = count == (PTR_BITS+1)'(JOB_DEPTH);
  assign empty = count == '0;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

[src/h264d_back.sv]
module h264d_back import h264d_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  job_t    head,
  input  logic    empty,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_item
);

  logic       started;
  logic [2:0] phase;
  logic [2:0] start_ph, cur, nxt;
  logic       last, load;
  result_t    item;

  always_comb begin
    start_ph = head.start_code ? PH_SC0 : (head.has_byte ? PH_BYTE : PH_END);
    cur = started ? phase : start_ph;
    if (cur == PH_SC3)       nxt = head.has_byte ? PH_BYTE : PH_END;
    else if (cur == PH_BYTE) nxt = PH_END;
    else                     nxt = cur + 3'd1;
    last = (cur == PH_END) || (cur == PH_BYTE && !head.frame_end) ||
           (cur == PH_SC3 && !head.has_byte && !head.frame_end);

    item.item_kind    = KIND_BYTE;
    item.stream_byte  = '0;
    item.key_frame    = 1'b0;
    item.frame_length = '0;
    item.last_of_run  = last;
    case (cur)
      PH_BYTE: item.stream_byte = head.data;
      PH_END: begin
        item.item_kind    = KIND_FRAME_END;
        item.key_frame    = head.key;
        item.frame_length = head.length;
      end
      default: item.stream_byte = (cur == PH_SC3) ? 8'd1 : 8'd0;
    endcase

    load = !empty && (!out_valid || !out_stall);
    pop  = load && last;
  end

  always_ff @(posedge clk) begin
    if (load) out_item <= item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      started   <= 1'b0;
      phase     <= PH_SC0;
    end else begin
      if (load)            out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (load) begin
        // advance within the job, or release it on its last result
        started <= !last;
        phase   <= nxt;
      end
    end
  end

endmodule

[src/h264_rtp_depacketizer.sv]
// H.264 RTP depacketizer: takes RTP packets one byte per beat (length given with
// the first byte), parses the 12-byte header and emits an Annex B stream with
// 00 00 00 01 start codes for single NAL, STAP-A and FU-A payloads, plus a
// frame-end beat (key flag, byte count) on a timestamp change or after a
// marker packet. The parser takes one input byte per cycle unless the queue is
// full and turns it into a job of zero to six results in the same cycle; jobs
// pass through a 4-entry queue to an output sequencer that issues one result per
// cycle while out_stall is low. A byte that yields N results (four for a start
// code alone, five for a start code with its NAL header byte, one more with a
// frame end) takes N output slots; input stall rises only when the queue is
// full. No clearing pass after reset.
module h264_rtp_depacketizer import h264d_pkg::*; #(
  parameter int FRAME_COUNT_BITS = DEFAULT_FRAME_COUNT_BITS
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  in_t     in_item,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_item
);

  logic q_full, q_push, q_empty, q_pop;
  job_t q_job, q_head;

  h264d_front #(
    .FRAME_COUNT_BITS(FRAME_COUNT_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_job)
  );

  h264d_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_job),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  h264d_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .empty     (q_empty),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

[test/h264_stream_checker.sv]
`timescale 1ns / 1ps

module h264_stream_checker import h264d_pkg::*; #(
  parameter int FRAME_COUNT_BITS = DEFAULT_FRAME_COUNT_BITS
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_stall,
  input  in_t     in_item,
  input  logic    out_valid,
  input  logic    out_stall,
  input  result_t out_item,
  output int      mismatches,
  output int      pending,
  output int      stream_bytes_seen,
  output int      frame_ends_seen
);

  localparam logic [32:0] COUNT_CAP = (33'd1 << FRAME_COUNT_BITS) - 33'd1;

  // Parser state of the predictor
  logic [15:0] pos;
  logic [15:0] pkt_len;
  logic [23:0] stamp_acc;
  logic [31:0] prev_stamp;
  logic        frame_is_open;
  logic        marker_seen;
  mode_t       mode;
  logic [7:0]  ind_byte;
  logic [1:0]  phase;
  logic [15:0] unit_left;
  logic        idr_seen;
  logic [32:0] frame_count;

  result_t expected_stream[$];
  result_t beat_results[$];

  task automatic emit(input logic kind, input logic [7:0] b, input logic key,
                      input logic [23:0] len);
    result_t r;
    r.item_kind    = kind;
    r.stream_byte  = b;
    r.key_frame    = key;
    r.frame_length = len;
    r.last_of_run  = 1'b0;
    beat_results = {beat_results, r};
  endtask

  task automatic emit_byte(input logic [7:0] b);
    emit(KIND_BYTE, b, 1'b0, 24'd0);
    if (frame_count < COUNT_CAP) frame_count = frame_count + 33'd1;
  endtask

  task automatic emit_start_code();
    emit_byte(8'h00);
    emit_byte(8'h00);
    emit_byte(8'h00);
    emit_byte(8'h01);
  endtask

  task automatic close_frame();
    emit(KIND_FRAME_END, 8'h00, idr_seen, frame_count[23:0]);
    idr_seen      = 1'b0;
    frame_count   = '0;
    frame_is_open = 1'b0;
  endtask

  task automatic aggregate_beat(input logic [7:0] b, input logic [15:0] idx);
    int unsigned here;
    int unsigned need;
    logic [15:0] size;
    here = int'(pkt_len) - int'(idx);  // bytes left, this one included
    if (phase == AGG_SIZE_HI || phase == AGG_FIRST_HI) begin
      need = (phase == AGG_FIRST_HI) ? 2 : 3;
      if (here < need) begin
        mode = MODE_DROP;
        return;
      end
      unit_left = {b, 8'h00};
      phase     = AGG_SIZE_LO;
    end else if (phase == AGG_SIZE_LO) begin
      size = {unit_left[15:8], b};
      if (int'(size) > here - 1) begin
        mode = MODE_DROP;
        return;
      end
      emit_start_code();
      if (size == 16'd0) begin
        phase = AGG_SIZE_HI;
      end else begin
        unit_left = size;
        ind_byte  = 8'd1;  // first unit byte still to come
        phase     = AGG_UNIT;
      end
    end else begin
      if (ind_byte != 8'd0 && b[4:0] == NAL_IDR) idr_seen = 1'b1;
      ind_byte = 8'd0;
      emit_byte(b);
      unit_left = unit_left - 16'd1;
      if (unit_left == 16'd0) phase = AGG_SIZE_HI;
    end
  endtask

  task automatic depacketize_beat(input in_t it);
    logic [15:0] idx;
    logic [7:0]  b;
    logic [4:0]  t;
    beat_results.delete();
    b = it.rx_byte;
    if (it.packet_start) begin
      pkt_len = it.packet_length;
      pos     = 16'd0;
      phase   = AGG_SIZE_HI;
      mode    = (pkt_len >= HEADER_BYTES) ? MODE_HEADER : MODE_IDLE;
    end
    if (mode != MODE_IDLE) begin
      idx = pos;
      pos = pos + 16'd1;
      case (mode)
        MODE_HEADER: begin
          if (idx == IDX_MARKER) begin
            marker_seen = b[7];
          end else if (idx >= IDX_STAMP_FIRST && idx < IDX_STAMP_LAST) begin
            stamp_acc = {stamp_acc[15:0], b};
          end else if (idx == IDX_STAMP_LAST) begin
            if (frame_is_open && {stamp_acc, b} != prev_stamp) close_frame();
            frame_is_open = 1'b1;
            prev_stamp    = {stamp_acc, b};
          end else if (idx == IDX_HEADER_LAST) begin
            mode = MODE_SELECT;
          end
        end
        MODE_SELECT: begin
          t = b[4:0];
          if (t == NAL_IDR) idr_seen = 1'b1;
          if (t >= NAL_SINGLE_MIN && t <= NAL_SINGLE_MAX) begin
            emit_start_code();
            emit_byte(b);
            mode = MODE_SINGLE;
          end else if (t == NAL_STAP_A) begin
            phase = AGG_FIRST_HI;
            mode  = MODE_STAP;
          end else if (t == NAL_FU_A) begin
            ind_byte = b;
            phase    = FU_HDR;
            mode     = MODE_FU;
          end else begin
            mode = MODE_DROP;
          end
        end
        MODE_SINGLE: emit_byte(b);
        MODE_STAP:   aggregate_beat(b, idx);
        MODE_FU: begin
          if (phase == FU_HDR) begin
            t = b[4:0];
            if (t == NAL_IDR) idr_seen = 1'b1;
            // rebuild the NAL header on a start fragment
            if (b[7]) begin
              emit_start_code();
              emit_byte((ind_byte & NRI_MASK) | {3'b000, t});
            end
            phase = FU_BODY;
          end else begin
            emit_byte(b);
          end
        end
        default: ;
      endcase
      if ({16'd0, idx} + 32'd1 >= {16'd0, pkt_len}) begin
        if (marker_seen) close_frame();
        mode = MODE_IDLE;
      end
    end
    if (beat_results.size() > 0)
      beat_results[beat_results.size() - 1].last_of_run = 1'b1;
    expected_stream = {expected_stream, beat_results};
  endtask

  task automatic check_field(input string name, input logic [23:0] want,
                             input logic [23:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (expected_stream.size() == 0) begin
      mismatches++;
      $display("%0t: result with nothing expected: expected none, actual %0h",
               $time, got);
      return;
    end
    want = expected_stream[0];
    expected_stream.delete(0);
    check_field("item_kind", 24'(want.item_kind), 24'(got.item_kind));
    check_field("stream_byte", 24'(want.stream_byte), 24'(got.stream_byte));
    check_field("key_frame", 24'(want.key_frame), 24'(got.key_frame));
    check_field("frame_length", want.frame_length, got.frame_length);
    check_field("last_of_run", 24'(want.last_of_run), 24'(got.last_of_run));
    if (want.item_kind == KIND_FRAME_END) frame_ends_seen++;
    else stream_bytes_seen++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pos               = '0;
      pkt_len           = '0;
      stamp_acc         = '0;
      prev_stamp        = '0;
      frame_is_open     = 1'b0;
      marker_seen       = 1'b0;
      mode              = MODE_IDLE;
      ind_byte          = '0;
      phase             = AGG_SIZE_HI;
      unit_left         = '0;
      idr_seen          = 1'b0;
      frame_count       = '0;
      expected_stream.delete();
      mismatches        = 0;
      stream_bytes_seen = 0;
      frame_ends_seen   = 0;
      pending           <= 0;
    end else begin
      // predict first, then check any result leaving in this beat
      if (in_valid && !in_stall) depacketize_beat(in_item);
      if (out_valid && !out_stall) check_result(out_item);
      pending <= expected_stream.size();
    end
  end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import h264d_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEM_TARGET = 210;

  typedef logic [7:0] octet_t;

  typedef enum int {
    PK_SINGLE,
    PK_STAP,
    PK_FU,
    PK_OTHER,
    PK_SHORT,
    PK_RESTART,
    PK_STRAY
  } pkt_kind_t;

  logic    clk;
  logic    rst;
  logic    in_valid;
  logic    in_stall;
  in_t     in_item;
  logic    out_valid;
  logic    out_stall;
  result_t out_item;

  int mismatches;
  int pending;
  int stream_bytes_seen;
  int frame_ends_seen;

  int in_idle_pct;
  int out_idle_pct;
  int cycle_count;
  int beats_sent;
  int packets_sent;

  logic [31:0] cur_stamp;
  octet_t      pkt[$];

  h264_rtp_depacketizer dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  h264_stream_checker checker_i (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_item          (in_item),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_item         (out_item),
    .mismatches       (mismatches),
    .pending          (pending),
    .stream_bytes_seen(stream_bytes_seen),
    .frame_ends_seen  (frame_ends_seen)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    out_stall   <= ($urandom_range(99) < out_idle_pct);
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_beat(input octet_t b, input logic start, input logic [15:0] len);
    in_t  it;
    logic taken;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    it.rx_byte       = b;
    it.packet_start  = start;
    it.packet_length = start ? len : 16'($urandom);
    in_valid <= 1'b1;
    in_item  <= it;
    // stall is settled by the falling edge; inputs hold until the next rise
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    beats_sent++;
  endtask

  // hold off input until every predicted result has come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // move through the idling phases as the beat count grows
  task automatic update_idling();
    if (beats_sent >= ITEM_TARGET / 3 && in_idle_pct == 13) begin
      drain();
      in_idle_pct  = 54;
      out_idle_pct = 13;
    end else if (beats_sent >= 2 * ITEM_TARGET / 3 && in_idle_pct == 54) begin
      drain();
      in_idle_pct  = 0;
      out_idle_pct = 0;
    end
  endtask

  task automatic send_packet(input int declared);
    update_idling();
    for (int i = 0; i < pkt.size(); i++) send_beat(pkt[i], i == 0, 16'(declared));
    packets_sent++;
  endtask

  task automatic append(input logic [63:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) pkt = {pkt, v[8*i +: 8]};
  endtask

  task automatic add_random_bytes(input int n);
    repeat (n) pkt = {pkt, 8'($urandom)};
  endtask

  task automatic start_header(input logic marker, input logic [31:0] stamp);
    logic [7:0] r;
    pkt.delete();
    pkt = {pkt, 8'($urandom)};
    r = 8'($urandom);
    pkt = {pkt, {marker, r[6:0]}};
    add_random_bytes(2);
    append(64'(stamp), 4);
    add_random_bytes(4);
  endtask

  function automatic octet_t nal_head(input logic [4:0] t);
    logic [7:0] r;
    r = 8'($urandom);
    return {r[7:5], t};
  endfunction

  function automatic logic [4:0] maybe_idr(input logic [4:0] t);
    return ($urandom_range(99) < 30) ? NAL_IDR : t;
  endfunction

  task automatic random_packet();
    pkt_kind_t  kind;
    int         pick;
    int         size;
    int         declared;
    logic [4:0] t;
    logic [7:0] r;
    if ($urandom_range(99) < 35) cur_stamp = $urandom;
    pick = $urandom_range(99);
    kind = pick < 25 ? PK_SINGLE : pick < 45 ? PK_STAP : pick < 72 ? PK_FU :
           pick < 80 ? PK_OTHER : pick < 86 ? PK_SHORT : pick < 93 ? PK_RESTART : PK_STRAY;
    start_header($urandom_range(99) < 30, cur_stamp);
    declared = -1;
    case (kind)
      PK_SINGLE, PK_RESTART, PK_STRAY: begin
        t = 5'($urandom_range(NAL_SINGLE_MIN, NAL_SINGLE_MAX));
        pkt = {pkt, nal_head(maybe_idr(t))};
        add_random_bytes($urandom_range(0, 6));
        if (kind == PK_RESTART) begin
          declared = ($urandom_range(3) == 0) ? 65535 :
                     pkt.size() + $urandom_range(1, 200);
        end else if (kind == PK_STRAY) begin
          declared = pkt.size();
          add_random_bytes($urandom_range(1, 3));
        end
      end
      PK_STAP: begin
        pkt = {pkt, nal_head(NAL_STAP_A)};
        repeat ($urandom_range(0, 3)) begin
          size = ($urandom_range(99) < 12) ? 0 : $urandom_range(1, 5);
          append(64'(size), 2);
          if (size > 0) begin
            pkt = {pkt, nal_head(maybe_idr(5'($urandom_range(1, 23))))};
            add_random_bytes(size - 1);
          end
        end
        case ($urandom_range(9))
          0, 1: begin
            // a size that mostly overruns the packet
            add_random_bytes(2);
            add_random_bytes($urandom_range(0, 3));
          end
          2, 3: add_random_bytes($urandom_range(1, 2));
          default: ;
        endcase
      end
      PK_FU: begin
        pkt = {pkt, nal_head(NAL_FU_A)};
        if ($urandom_range(99) >= 10) begin
          r = 8'($urandom);
          r[4:0] = maybe_idr(r[4:0]);
          pkt = {pkt, r};
          add_random_bytes($urandom_range(0, 6));
        end
      end
      PK_OTHER: begin
        do t = 5'($urandom);
        while ((t >= NAL_SINGLE_MIN && t <= NAL_STAP_A) || t == NAL_FU_A);
        pkt = {pkt, nal_head(t)};
        add_random_bytes($urandom_range(0, 3));
      end
      PK_SHORT: begin
        pkt.delete();
        declared = $urandom_range(0, 11);
        add_random_bytes(declared == 0 ? 1 : declared);
      end
      default: ;
    endcase
    if (declared < 0) declared = pkt.size();
    send_packet(declared);
  endtask

  initial begin
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    in_item      <= '0;
    out_stall    <= 1'b0;
    cycle_count  <= 0;
    beats_sent   = 0;
    packets_sent = 0;
    in_idle_pct  = 13;
    out_idle_pct = 54;
    cur_stamp    = 32'h0000_1000;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // stray byte with nothing open, then packets too short to parse
    send_beat(8'hff, 1'b0, 16'hffff);
    pkt.delete();
    append(64'h80_12_34_56_78, 5);
    send_packet(5);
    pkt.delete();
    append(64'h00, 1);
    send_packet(0);

    // single IDR NAL, then an empty marker packet on the same stamp
    start_header(1'b0, 32'h0000_1000);
    append(64'h65_ff_00_80, 4);
    send_packet(pkt.size());
    start_header(1'b1, 32'h0000_1000);
    send_packet(pkt.size());

    // STAP-A: zero-size unit, IDR unit, plain unit, two trailing bytes
    start_header(1'b0, 32'hffff_ffff);
    append(64'h78_00_00_00_02_65_aa_00, 8);
    append(64'h01_41_00_05, 4);
    send_packet(pkt.size());
    // STAP-A unit larger than the packet
    start_header(1'b0, 32'hffff_ffff);
    append(64'h18_00_09_01_02_03, 6);
    send_packet(pkt.size());

    // FU-A start (new stamp closes the frame), middle, end with marker
    start_header(1'b0, 32'h8000_0000);
    append(64'h7c_85_de_ad_01, 5);
    send_packet(pkt.size());
    start_header(1'b0, 32'h8000_0000);
    append(64'h7c_05_be_ef, 4);
    send_packet(pkt.size());
    start_header(1'b1, 32'h8000_0000);
    append(64'h5c_45_77, 3);
    send_packet(pkt.size());

    // FU indicator alone, then an unknown type closing an empty frame
    start_header(1'b0, 32'h0000_0001);
    append(64'h1c, 1);
    send_packet(pkt.size());
    start_header(1'b1, 32'h0000_0001);
    append(64'h19_12, 2);
    send_packet(pkt.size());

    // packet cut short by the next start, which ends early with strays behind
    start_header(1'b0, 32'h1234_5678);
    append(64'h41_01_02, 3);
    send_packet(65535);
    start_header(1'b1, 32'h1234_5678);
    append(64'h00_aa_bb_cc, 4);
    send_packet(14);

    while (beats_sent < ITEM_TARGET) random_packet();

    drain();
    repeat (30) @(posedge clk);
    $display("tb: %0d packets in %0d input beats, idling 13/54, 54/13 and none",
             packets_sent, beats_sent);
    $display("tb: checked %0d stream bytes and %0d frame ends",
             stream_bytes_seen, frame_ends_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
